// ===== src/fbfr_pkg.sv =====
package fbfr_pkg;

  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [7:0] TypeByte  = 8'h11;
  localparam logic [7:0] RegFan    = 8'h29;
  localparam logic [7:0] RegTempLo = 8'h32;
  localparam logic [7:0] RegTempHi = 8'h35;

  localparam int unsigned PosW     = 3;
  localparam int unsigned NumTemps = 4;
  localparam int unsigned TempIdxW = $clog2(NumTemps);

  // frame positions of the bytes that are kept
  localparam logic [PosW-1:0] PosStart = 3'd0;
  localparam logic [PosW-1:0] PosType  = 3'd1;
  localparam logic [PosW-1:0] PosReg   = 3'd3;
  localparam logic [PosW-1:0] PosVal   = 3'd4;
  localparam logic [PosW-1:0] PosSum   = 3'd5;

  // items held between the input and output ports at most
  localparam int unsigned PipeDepth = 2;
  localparam int unsigned OccW      = $clog2(PipeDepth + 1);

  typedef logic [NumTemps-1:0][7:0] temps_t;

endpackage

// ===== src/fan_bus_frame_receiver_top.sv =====
// Frame receiver for a ventilation-unit RS485 bus.
// Input channel: one received UART byte per item (rx_byte_i, line_error_i),
// qualified by in_valid_i and held back by in_stall_o.
// Output channel: one result per input item (out_valid_o / out_stall_i):
// frame_done_o, checksum_ok_o, value_changed_o and the stored fan level and
// four temperatures as they stand after that byte.
// A frame is 0x01, four body bytes and an additive checksum byte. A good
// frame of type 0x11 writes register 0x29 (fan) or 0x32..0x35 (temps).
// An accepted item passes the input register and then the result register
// before out_valid_o rises with its result. The receiver takes one item per
// cycle while the output is not stalled; the frame state is a single short
// update between the two registers.
// Reset clears the frame position, the checksum, the fan level and the
// temperatures; both pipeline stages come up empty.
// When the receiver stalls, the result is held; if the input register is
// empty, one more item is still taken into it, after which in_stall_o stays
// high until the result is taken.
module fan_bus_frame_receiver_top
  import fbfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       line_error_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_done_o,
  output logic       checksum_ok_o,
  output logic       value_changed_o,
  output logic [7:0] fan_level_o,
  output logic [7:0] temp_a_o,
  output logic [7:0] temp_b_o,
  output logic [7:0] temp_c_o,
  output logic [7:0] temp_d_o
);

  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_err_q;
  logic            out_valid_q;
  logic            adv_out;
  logic            move;
  logic            in_acc;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      reg_q, reg_d;
  logic [7:0]      val_q, val_d;
  logic [7:0]      fan_q, fan_d;
  temps_t          temps_q, temps_d;

  logic            done, ok, chg;
  logic [7:0]      sum_base;
  logic [7:0]      idx_full;
  logic [TempIdxW-1:0] idx;

  logic            done_q, ok_q, chg_q;
  logic [7:0]      fan_res_q;
  temps_t          temps_res_q;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign move       = s1_valid_q && adv_out;
  assign in_stall_o = s1_valid_q && !adv_out;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_full = reg_q - RegTempLo;
  assign idx      = idx_full[TempIdxW-1:0];

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    type_d   = type_q;
    reg_d    = reg_q;
    val_d    = val_q;
    fan_d    = fan_q;
    temps_d  = temps_q;
    done     = 1'b0;
    ok       = 1'b0;
    chg      = 1'b0;
    sum_base = (pos_q == PosStart) ? 8'h00 : sum_q;
    if (s1_err_q) begin
      pos_d = PosStart;
    end else if (pos_q >= PosSum) begin
      done  = 1'b1;
      ok    = (s1_byte_q == sum_q);
      pos_d = PosStart;
      if (ok && type_q == TypeByte) begin
        if (reg_q == RegFan) begin
          chg   = (fan_q != val_q);
          fan_d = val_q;
        end else if (reg_q >= RegTempLo && reg_q <= RegTempHi) begin
          chg          = (temps_q[idx] != val_q);
          temps_d[idx] = val_q;
        end
      end
    end else if (pos_q == PosStart && s1_byte_q != StartByte) begin
      pos_d = PosStart;
    end else begin
      sum_d = sum_base + s1_byte_q;
      pos_d = pos_q + 3'd1;
      unique case (pos_q)
        PosType: type_d = s1_byte_q;
        PosReg:  reg_d  = s1_byte_q;
        PosVal:  val_d  = s1_byte_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= PosStart;
      sum_q       <= 8'h00;
      fan_q       <= 8'h00;
      temps_q     <= '0;
    end else begin
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (move) begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        fan_q   <= fan_d;
        temps_q <= temps_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
      s1_err_q  <= line_error_i;
    end
    if (move) begin
      type_q      <= type_d;
      reg_q       <= reg_d;
      val_q       <= val_d;
      done_q      <= done;
      ok_q        <= ok;
      chg_q       <= chg;
      fan_res_q   <= fan_d;
      temps_res_q <= temps_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = done_q;
  assign checksum_ok_o   = ok_q;
  assign value_changed_o = chg_q;
  assign fan_level_o     = fan_res_q;
  assign temp_a_o        = temps_res_q[0];
  assign temp_b_o        = temps_res_q[1];
  assign temp_c_o        = temps_res_q[2];
  assign temp_d_o        = temps_res_q[3];

endmodule

// ===== src/fbfr_checker.sv =====
module fbfr_checker
  import fbfr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       frame_done_o,
  input logic       checksum_ok_o,
  input logic       value_changed_o,
  input logic [7:0] fan_level_o
);

  logic            in_acc, out_acc;
  logic [OccW-1:0] occ_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_acc && !out_acc) begin
      occ_q <= occ_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  a_no_invented_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("result without an outstanding item");

  a_bounded_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OccW'(PipeDepth) |-> in_stall_o || out_acc)
    else $error("item taken with both stages full");

  a_change_needs_good_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (value_changed_o || checksum_ok_o) |-> frame_done_o &&
    checksum_ok_o)
    else $error("change or checksum flag outside a good frame");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fan_level_o))
    else $error("stalled result changed");

endmodule

bind fan_bus_frame_receiver_top fbfr_checker u_fbfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .frame_done_o    (frame_done_o),
  .checksum_ok_o   (checksum_ok_o),
  .value_changed_o (value_changed_o),
  .fan_level_o     (fan_level_o)
);
